@@ hdl/phsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsm_pkg
// Shared types and constants of the peer heartbeat stale monitor.
// ----------------------------------------------------------------------------
package phsm_pkg;

  localparam int PeerW      = 9;
  localparam int WideW      = 64;
  localparam int IdentW     = 32;
  localparam int TimeoutW   = 32;
  localparam int CfgIndexW  = 2;
  localparam int PeerCmpW   = 17;
  localparam int MaxPeersDefault = 256;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_UNSTABLE  = 3'd2,
    ST_STALE_GEN = 3'd3,
    ST_CORRUPT   = 3'd4
  } status_t;

  localparam logic [CfgIndexW-1:0] CFG_SESSION  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LIMIT    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic [IdentW-1:0] LC_STARTING = 32'd1;
  localparam logic [IdentW-1:0] LC_RETIRED  = 32'd4;
  localparam logic [IdentW-1:0] LC_FAULTED  = 32'd5;

  typedef struct packed {
    logic             lookup;
    status_t          status;
    logic             stale;
    logic [PeerW-1:0] peer;
    logic [WideW-1:0] generation;
    logic [WideW-1:0] heartbeat;
    logic [WideW-1:0] obs_time;
  } op_t;

endpackage
`default_nettype wire

@@ hdl/phsm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsm_front
// Accepts observation words and classifies them into final results or
// table lookups for the back end.
// ----------------------------------------------------------------------------
module phsm_front #(
  parameter int MAX_PEERS = phsm_pkg::MaxPeersDefault
) (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [phsm_pkg::PeerW-1:0]     peer_id,
  input  wire logic                           record_stable,
  input  wire logic [phsm_pkg::WideW-1:0]     record_sequence,
  input  wire logic [phsm_pkg::WideW-1:0]     record_session,
  input  wire logic [phsm_pkg::IdentW-1:0]    record_peer,
  input  wire logic [phsm_pkg::IdentW-1:0]    record_lifecycle,
  input  wire logic [phsm_pkg::WideW-1:0]     record_generation,
  input  wire logic [phsm_pkg::WideW-1:0]     record_heartbeat,
  input  wire logic [phsm_pkg::WideW-1:0]     observe_time,
  input  wire logic [phsm_pkg::WideW-1:0]     session_generation,
  input  wire logic [phsm_pkg::PeerW-1:0]     endpoint_limit,
  input  wire logic [phsm_pkg::TimeoutW-1:0]  timeout_ticks,
  input  wire logic                           queue_full,
  input  wire logic                           clear_busy,
  output logic                                push,
  output phsm_pkg::op_t                       push_data
);

  logic bad_peer;
  logic bad_record;
  logic bad_life;
  logic gone;

  assign in_ready = !queue_full && !clear_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    bad_peer = (peer_id == '0) || (peer_id > endpoint_limit) ||
               (phsm_pkg::PeerCmpW'(peer_id) > phsm_pkg::PeerCmpW'(MAX_PEERS));
    bad_record = (record_sequence == '0) || record_sequence[0] ||
                 (record_session != session_generation) ||
                 (record_peer != {{(phsm_pkg::IdentW-phsm_pkg::PeerW){1'b0}}, peer_id}) ||
                 (record_generation == '0);
    bad_life = (record_lifecycle < phsm_pkg::LC_STARTING) ||
               (record_lifecycle > phsm_pkg::LC_FAULTED);
    gone = (record_lifecycle == phsm_pkg::LC_FAULTED) ||
           (record_lifecycle == phsm_pkg::LC_RETIRED);

    push_data.lookup     = 1'b0;
    push_data.status     = phsm_pkg::ST_OK;
    push_data.stale      = 1'b0;
    push_data.peer       = peer_id;
    push_data.generation = record_generation;
    push_data.heartbeat  = record_heartbeat;
    push_data.obs_time   = observe_time;

    priority if (timeout_ticks == '0) begin
      push_data.status = phsm_pkg::ST_INVALID;
    end else if (bad_peer) begin
      push_data.status = phsm_pkg::ST_INVALID;
    end else if (!record_stable) begin
      push_data.status = phsm_pkg::ST_UNSTABLE;
    end else if (bad_record) begin
      push_data.status = phsm_pkg::ST_STALE_GEN;
    end else if (bad_life) begin
      push_data.status = phsm_pkg::ST_CORRUPT;
    end else if (gone) begin
      push_data.stale = 1'b1;
    end else begin
      push_data.lookup = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/phsm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsm_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module phsm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire phsm_pkg::op_t push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output phsm_pkg::op_t      head
);

  phsm_pkg::op_t                   entries [phsm_pkg::QueueDepth];
  logic [phsm_pkg::QPtrW-1:0]      wr_ptr;
  logic [phsm_pkg::QPtrW-1:0]      rd_ptr;
  logic [phsm_pkg::QCntW-1:0]      count;

  assign full       = (count == phsm_pkg::QCntW'(phsm_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + phsm_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + phsm_pkg::QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + phsm_pkg::QCntW'(1);
        2'b01:   count <= count - phsm_pkg::QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/phsm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phsm_back
// Peer table and result register: clears the table after reset, looks up
// and updates peer entries, and holds the result word for the output.
// ----------------------------------------------------------------------------
module phsm_back #(
  parameter int MAX_PEERS = phsm_pkg::MaxPeersDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [phsm_pkg::TimeoutW-1:0]  timeout_ticks,
  input  wire logic                           head_valid,
  input  wire phsm_pkg::op_t                  head,
  output logic                                pop,
  output logic                                clear_busy,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output phsm_pkg::status_t                   out_status,
  output logic                                out_stale
);

  localparam int SlotW  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int EntryW = 1 + 3 * phsm_pkg::WideW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_PEERS - 1);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    EVAL
  } state_t;

  state_t                       state;
  logic [SlotW-1:0]             clr_idx;
  phsm_pkg::op_t                cur;

  logic [EntryW-1:0]            mem [MAX_PEERS];
  logic [EntryW-1:0]            rd_data;
  logic [SlotW-1:0]             rd_addr;
  logic                         wr_en;
  logic [SlotW-1:0]             wr_addr;
  logic [EntryW-1:0]            wr_data;

  logic                         seen_valid;
  logic [phsm_pkg::WideW-1:0]   seen_generation;
  logic [phsm_pkg::WideW-1:0]   seen_heartbeat;
  logic [phsm_pkg::WideW-1:0]   progress_time;
  logic                         hit;
  logic [phsm_pkg::WideW:0]     elapsed;
  logic                         lookup_stale;
  logic                         out_free;

  function automatic logic [SlotW-1:0] slot_of(input logic [phsm_pkg::PeerW-1:0] peer);
    logic [phsm_pkg::PeerCmpW-1:0] idx;
    idx = phsm_pkg::PeerCmpW'(peer) - phsm_pkg::PeerCmpW'(1);
    return SlotW'(idx);
  endfunction

  assign rd_addr = slot_of(head.peer);
  assign {seen_valid, seen_generation, seen_heartbeat, progress_time} = rd_data;

  assign clear_busy = (state == CLEAR);
  assign out_free   = !out_valid || out_ready;
  assign pop        = (state == IDLE) && head_valid && out_free;

  always_comb begin
    hit = seen_valid && (seen_generation == cur.generation) &&
          (seen_heartbeat == cur.heartbeat);
    elapsed = {1'b0, cur.obs_time} - {1'b0, progress_time};
    lookup_stale = hit && !elapsed[phsm_pkg::WideW] &&
                   (elapsed[phsm_pkg::WideW-1:0] >=
                    {{(phsm_pkg::WideW-phsm_pkg::TimeoutW){1'b0}}, timeout_ticks});

    wr_en   = 1'b0;
    wr_addr = slot_of(cur.peer);
    wr_data = {1'b1, cur.generation, cur.heartbeat, cur.obs_time};
    unique case (state)
      CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      EVAL: begin
        wr_en = !hit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      out_status <= phsm_pkg::ST_OK;
      out_stale  <= 1'b0;
    end else begin
      unique case (state)
        CLEAR: begin
          clr_idx   <= clr_idx + SlotW'(1);
          out_valid <= 1'b0;
          if (clr_idx == LastSlot) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (pop) begin
            if (head.lookup) begin
              cur       <= head;
              out_valid <= 1'b0;
              state     <= EVAL;
            end else begin
              out_valid  <= 1'b1;
              out_status <= head.status;
              out_stale  <= head.stale;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        EVAL: begin
          out_valid  <= 1'b1;
          out_status <= phsm_pkg::ST_OK;
          out_stale  <= lookup_stale;
          state      <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/peer_heartbeat_stale_monitor_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// peer_heartbeat_stale_monitor_top
// Judges from one observed peer record whether that peer is stale.
// ----------------------------------------------------------------------------
// The front end classifies each accepted word in its accept cycle and places
// it in a two-entry queue. Words rejected by the checks, and retired or
// faulted peers, go from the queue head straight into the result register;
// table lookups pass the registered read of the peer table and then the EVAL
// state, which compares, updates and loads the result, and the back end takes
// no new word from the queue until a lookup is done. After reset the back end
// clears the peer table, one entry a cycle, with in_ready low; configuration
// writes are taken at any time and must only be issued while the block is
// idle.
// ----------------------------------------------------------------------------
module peer_heartbeat_stale_monitor_top #(
  parameter int MAX_PEERS = phsm_pkg::MaxPeersDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [phsm_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [phsm_pkg::WideW-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [phsm_pkg::PeerW-1:0]      peer_id,
  input  wire logic                            record_stable,
  input  wire logic [phsm_pkg::WideW-1:0]      record_sequence,
  input  wire logic [phsm_pkg::WideW-1:0]      record_session,
  input  wire logic [phsm_pkg::IdentW-1:0]     record_peer,
  input  wire logic [phsm_pkg::IdentW-1:0]     record_lifecycle,
  input  wire logic [phsm_pkg::WideW-1:0]      record_generation,
  input  wire logic [phsm_pkg::WideW-1:0]      record_heartbeat,
  input  wire logic [phsm_pkg::WideW-1:0]      observe_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           status,
  output logic                                 stale
);

  logic [phsm_pkg::WideW-1:0]    session_generation;
  logic [phsm_pkg::PeerW-1:0]    endpoint_limit;
  logic [phsm_pkg::TimeoutW-1:0] timeout_ticks;

  logic              push;
  phsm_pkg::op_t     push_data;
  logic              pop;
  logic              queue_full;
  logic              head_valid;
  phsm_pkg::op_t     head;
  logic              clear_busy;
  phsm_pkg::status_t out_status;

  assign cfg_ready = 1'b1;
  assign status    = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_generation <= '0;
      endpoint_limit     <= '0;
      timeout_ticks      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        phsm_pkg::CFG_SESSION: session_generation <= cfg_data;
        phsm_pkg::CFG_LIMIT:   endpoint_limit     <= cfg_data[phsm_pkg::PeerW-1:0];
        phsm_pkg::CFG_TIMEOUT: timeout_ticks      <= cfg_data[phsm_pkg::TimeoutW-1:0];
        default: begin
          session_generation <= session_generation;
        end
      endcase
    end
  end

  phsm_front #(
    .MAX_PEERS(MAX_PEERS)
  ) u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .peer_id            (peer_id),
    .record_stable      (record_stable),
    .record_sequence    (record_sequence),
    .record_session     (record_session),
    .record_peer        (record_peer),
    .record_lifecycle   (record_lifecycle),
    .record_generation  (record_generation),
    .record_heartbeat   (record_heartbeat),
    .observe_time       (observe_time),
    .session_generation (session_generation),
    .endpoint_limit     (endpoint_limit),
    .timeout_ticks      (timeout_ticks),
    .queue_full         (queue_full),
    .clear_busy         (clear_busy),
    .push               (push),
    .push_data          (push_data)
  );

  phsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  phsm_back #(
    .MAX_PEERS(MAX_PEERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .clear_busy    (clear_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_stale     (stale)
  );

  a_error_not_stale: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != phsm_pkg::ST_OK) |-> !stale)
    else $error("stale set on an error result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == phsm_pkg::ST_OK) || (out_status == phsm_pkg::ST_INVALID) ||
                  (out_status == phsm_pkg::ST_UNSTABLE) ||
                  (out_status == phsm_pkg::ST_STALE_GEN) ||
                  (out_status == phsm_pkg::ST_CORRUPT))
    else $error("status code out of range");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready && !out_valid)
    else $error("input taken before table clear");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && !clear_busy)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ tb/stale_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// stale_verdict_checker
// Watches the configuration, observation and verdict channels of the stale
// monitor. It keeps its own copy of the registers and of the peer table,
// predicts the verdict of every accepted observation word, and compares each
// verdict word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module stale_verdict_checker #(
  parameter int MAX_PEERS = phsm_pkg::MaxPeersDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [phsm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [phsm_pkg::WideW-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [phsm_pkg::PeerW-1:0]     peer_id,
  input  logic                           record_stable,
  input  logic [phsm_pkg::WideW-1:0]     record_sequence,
  input  logic [phsm_pkg::WideW-1:0]     record_session,
  input  logic [phsm_pkg::IdentW-1:0]    record_peer,
  input  logic [phsm_pkg::IdentW-1:0]    record_lifecycle,
  input  logic [phsm_pkg::WideW-1:0]     record_generation,
  input  logic [phsm_pkg::WideW-1:0]     record_heartbeat,
  input  logic [phsm_pkg::WideW-1:0]     observe_time,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     status,
  input  logic                           stale,
  output int                             mismatches,
  output int                             outstanding
);
  import phsm_pkg::*;

  typedef struct packed {
    status_t status;
    logic    stale;
  } verdict_t;

  logic [WideW-1:0]    session_cfg;
  logic [PeerW-1:0]    limit_cfg;
  logic [TimeoutW-1:0] timeout_cfg;

  logic             tbl_valid [MAX_PEERS];
  logic [WideW-1:0] tbl_gen   [MAX_PEERS];
  logic [WideW-1:0] tbl_hb    [MAX_PEERS];
  logic [WideW-1:0] tbl_time  [MAX_PEERS];

  verdict_t owed_verdicts[$];
  int       errors;

  function automatic verdict_t judge_observation(
    input logic [PeerW-1:0]  p,
    input logic              stbl,
    input logic [WideW-1:0]  seq,
    input logic [WideW-1:0]  sess,
    input logic [IdentW-1:0] who,
    input logic [IdentW-1:0] life,
    input logic [WideW-1:0]  gen,
    input logic [WideW-1:0]  hb,
    input logic [WideW-1:0]  now
  );
    verdict_t v;
    int       slot;
    v.status = ST_OK;
    v.stale  = 1'b0;
    if (timeout_cfg == '0) begin
      v.status = ST_INVALID;
    end else if (p == '0 || p > limit_cfg || p > MAX_PEERS) begin
      v.status = ST_INVALID;
    end else if (!stbl) begin
      v.status = ST_UNSTABLE;
    end else if (seq == '0 || seq[0] || sess != session_cfg ||
                 who != {{(IdentW-PeerW){1'b0}}, p} || gen == '0) begin
      v.status = ST_STALE_GEN;
    end else if (life < LC_STARTING || life > LC_FAULTED) begin
      v.status = ST_CORRUPT;
    end else if (life == LC_RETIRED || life == LC_FAULTED) begin
      v.stale = 1'b1;
    end else begin
      slot = p - 1;
      if (!tbl_valid[slot] || tbl_gen[slot] != gen || tbl_hb[slot] != hb) begin
        tbl_valid[slot] = 1'b1;
        tbl_gen[slot]   = gen;
        tbl_hb[slot]    = hb;
        tbl_time[slot]  = now;
      end else if (now >= tbl_time[slot]) begin
        v.stale = (now - tbl_time[slot]) >= {{(WideW-TimeoutW){1'b0}}, timeout_cfg};
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      session_cfg = '0;
      limit_cfg   = '0;
      timeout_cfg = '0;
      for (int i = 0; i < MAX_PEERS; i++) tbl_valid[i] = 1'b0;
      owed_verdicts.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SESSION: session_cfg = cfg_data;
          CFG_LIMIT:   limit_cfg   = cfg_data[PeerW-1:0];
          CFG_TIMEOUT: timeout_cfg = cfg_data[TimeoutW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected verdict word: status %0d stale %0b", status, stale);
        end else begin
          want = owed_verdicts.pop_front();
          if (status !== want.status || stale !== want.stale) begin
            errors++;
            if (errors <= 10)
              $display("verdict mismatch: status %0d stale %0b, expected status %0d stale %0b",
                       status, stale, want.status, want.stale);
          end
        end
      end
      if (in_valid && in_ready)
        owed_verdicts.push_back(judge_observation(peer_id, record_stable, record_sequence,
                                                  record_session, record_peer,
                                                  record_lifecycle, record_generation,
                                                  record_heartbeat, observe_time));
    end
    mismatches  <= errors;
    outstanding <= owed_verdicts.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the peer heartbeat stale monitor. A directed pass
// walks every rejection, the retired and faulted shortcuts, the timeout
// boundary and time running backwards; random phases then mix well-formed
// heartbeat streams on a few hot peers with broken records and noise, under
// several register settings, bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
  import phsm_pkg::*;

  localparam int RunLimit   = 200000;
  localparam int HoldCycles = 150;
  localparam logic [IdentW-1:0] LC_READY    = 32'd2;
  localparam logic [IdentW-1:0] LC_DRAINING = 32'd3;

  typedef struct {
    logic [PeerW-1:0]  peer;
    logic              stable;
    logic [WideW-1:0]  seq;
    logic [WideW-1:0]  sess;
    logic [IdentW-1:0] who;
    logic [IdentW-1:0] life;
    logic [WideW-1:0]  gen;
    logic [WideW-1:0]  hb;
    logic [WideW-1:0]  now;
  } observation_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = CFG_SESSION;
  logic [WideW-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PeerW-1:0]     peer_id = '0;
  logic                 record_stable = 1'b0;
  logic [WideW-1:0]     record_sequence = '0;
  logic [WideW-1:0]     record_session = '0;
  logic [IdentW-1:0]    record_peer = '0;
  logic [IdentW-1:0]    record_lifecycle = '0;
  logic [WideW-1:0]     record_generation = '0;
  logic [WideW-1:0]     record_heartbeat = '0;
  logic [WideW-1:0]     observe_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           status;
  logic                 stale;
  int                   mismatches;
  int                   outstanding;

  logic [WideW-1:0]    cur_session = '0;
  logic [PeerW-1:0]    cur_limit = '0;
  logic [TimeoutW-1:0] cur_timeout = '0;

  logic             beat_known [1:256];
  logic [WideW-1:0] beat_gen   [1:256];
  logic [WideW-1:0] beat_hb    [1:256];
  logic [WideW-1:0] beat_time  [1:256];

  int   burst_left = 0;
  logic steady = 1'b0;
  int   rx_style = 2;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   rx_run = 0;
  logic rx_phase = 1'b0;
  int   cycle_count = 0;

  peer_heartbeat_stale_monitor_top dut (.*);
  stale_verdict_checker checker_inst (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_style == 0) begin
      out_ready <= 1'b1;
    end else if (rx_style == 1) begin
      if (rx_run == 0) begin
        rx_phase = ~rx_phase;
        rx_run   = rx_phase ? $urandom_range(1, 10) : $urandom_range(1, 6);
      end
      rx_run--;
      out_ready <= rx_phase;
    end else begin
      out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  function automatic logic [WideW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic observation_t clean(input int p, input logic [IdentW-1:0] life,
                                         input logic [WideW-1:0] gen,
                                         input logic [WideW-1:0] hb,
                                         input logic [WideW-1:0] now);
    observation_t o;
    o.peer   = PeerW'(p);
    o.stable = 1'b1;
    o.seq    = rand64();
    o.seq[0] = 1'b0;
    if (o.seq == '0) o.seq = 64'd2;
    o.sess = cur_session;
    o.who  = IdentW'(p);
    o.life = life;
    o.gen  = gen;
    o.hb   = hb;
    o.now  = now;
    return o;
  endfunction

  function automatic observation_t noise_word();
    observation_t o;
    o.peer   = PeerW'($urandom_range(0, 256));
    o.stable = 1'($urandom_range(0, 1));
    o.seq    = rand64();
    o.sess   = rand64();
    o.who    = $urandom;
    o.life   = $urandom;
    o.gen    = rand64();
    o.hb     = rand64();
    o.now    = rand64();
    return o;
  endfunction

  function automatic observation_t heartbeat_word();
    int                p;
    int                hot;
    int                k;
    logic [WideW-1:0]  base;
    logic [WideW-1:0]  span;
    logic [WideW-1:0]  gen;
    logic [WideW-1:0]  hb;
    logic [WideW-1:0]  now;
    logic [IdentW-1:0] life;
    hot  = (cur_limit < 6) ? cur_limit : 6;
    p    = ($urandom_range(0, 9) < 7) ? $urandom_range(1, hot) : $urandom_range(1, cur_limit);
    base = beat_time[p];
    span = {32'b0, cur_timeout};
    gen  = (beat_gen[p] == '0) ? 64'd1 : beat_gen[p];
    hb   = beat_hb[p];
    k    = $urandom_range(0, 19);
    if (k < 11) begin
      if (k < 8) begin
        hb = ($urandom_range(0, 3) == 0) ? rand64() : hb + 1;
      end else begin
        gen = rand64();
        if (gen == '0) gen = 64'd1;
      end
      now = ($urandom_range(0, 4) == 0) ? rand64() : base + $urandom_range(0, cur_timeout);
    end else begin
      case ($urandom_range(0, 6))
        0: now = base + span;
        1: now = base + span - 1;
        2: now = base + $urandom_range(0, cur_timeout);
        3: now = base + span + $urandom_range(1, 1000);
        4: now = base - $urandom_range(1, 1000);
        5: now = base + span + rand64();
        default: now = rand64();
      endcase
    end
    if ($urandom_range(0, 6) == 0)
      life = $urandom_range(0, 1) ? LC_RETIRED : LC_FAULTED;
    else
      life = LC_STARTING + $urandom_range(0, 2);
    return clean(p, life, gen, hb, now);
  endfunction

  function automatic observation_t spoil(input observation_t o);
    case ($urandom_range(0, 9))
      0: o.stable = 1'b0;
      1: o.seq[0] = 1'b1;
      2: o.seq = '0;
      3: o.sess = o.sess ^ (rand64() | 64'd1);
      4: o.who = o.who ^ ($urandom | 32'd1);
      5: o.gen = '0;
      6: o.life = '0;
      7: o.life = $urandom_range(6, 32'hFFFF_FFFF);
      8: o.peer = '0;
      default: o.peer = (cur_limit < 9'd256) ? PeerW'($urandom_range(cur_limit + 1, 256)) : '0;
    endcase
    return o;
  endfunction

  function automatic void track_progress(input observation_t o);
    if (cur_timeout != '0 && o.peer <= cur_limit && o.life <= LC_DRAINING) begin
      if (!beat_known[o.peer] || beat_gen[o.peer] != o.gen || beat_hb[o.peer] != o.hb) begin
        beat_known[o.peer] = 1'b1;
        beat_gen[o.peer]   = o.gen;
        beat_hb[o.peer]    = o.hb;
        beat_time[o.peer]  = o.now;
      end
    end
  endfunction

  function automatic observation_t pick_word();
    observation_t o;
    int           k;
    k = $urandom_range(0, 19);
    if (k < 3 || cur_limit == '0) return noise_word();
    o = heartbeat_word();
    if (k < 6) return spoil(o);
    track_progress(o);
    return o;
  endfunction

  task automatic offer(input observation_t o);
    int gap;
    if (burst_left == 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    peer_id           <= o.peer;
    record_stable     <= o.stable;
    record_sequence   <= o.seq;
    record_session    <= o.sess;
    record_peer       <= o.who;
    record_lifecycle  <= o.life;
    record_generation <= o.gen;
    record_heartbeat  <= o.hb;
    observe_time      <= o.now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [WideW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [WideW-1:0] sess, input logic [PeerW-1:0] lim,
                            input logic [TimeoutW-1:0] tmo);
    put_reg(CFG_SESSION, sess);
    put_reg(CFG_LIMIT, {{(WideW-PeerW){1'b0}}, lim});
    put_reg(CFG_TIMEOUT, {{(WideW-TimeoutW){1'b0}}, tmo});
    cfg_valid   <= 1'b0;
    cur_session = sess;
    cur_limit   = lim;
    cur_timeout = tmo;
  endtask

  task automatic run_phase(input logic [WideW-1:0] sess, input logic [PeerW-1:0] lim,
                           input logic [TimeoutW-1:0] tmo, input int count,
                           input logic with_hold);
    drain();
    set_config(sess, lim, tmo);
    rx_style = $urandom_range(0, 2);
    steady   = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 3) begin
        hold_requests++;
        steady = 1'b1;
      end
      if (n == count / 2) begin
        drain();
        steady = 1'b0;
      end
      offer(pick_word());
    end
  endtask

  initial begin
    observation_t o;
    for (int i = 1; i <= 256; i++) begin
      beat_known[i] = 1'b0;
      beat_gen[i]   = '0;
      beat_hb[i]    = '0;
      beat_time[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    offer(noise_word());
    offer(clean(1, LC_READY, 64'd1, 64'd1, 64'd0));
    drain();
    set_config(rand64(), 9'd255, 32'd3);

    o = clean(1, LC_READY, 64'd7, 64'd1, 64'd100);
    o.peer = '0;
    o.who  = '0;
    offer(o);
    offer(clean(256, LC_READY, 64'd7, 64'd1, 64'd100));
    o = clean(255, LC_READY, '1, '1, '1);
    o.seq = 64'hFFFF_FFFF_FFFF_FFFE;
    offer(o);
    o = clean(1, LC_READY, 64'd7, 64'd1, 64'd100);
    o.stable = 1'b0;
    offer(o);
    o = clean(1, LC_READY, 64'd7, 64'd1, 64'd100);
    o.seq = '0;
    offer(o);
    o.seq = 64'd3;
    offer(o);
    o = clean(1, LC_READY, 64'd7, 64'd1, 64'd100);
    o.sess = ~cur_session;
    offer(o);
    o = clean(1, LC_READY, 64'd7, 64'd1, 64'd100);
    o.who = 32'd2;
    offer(o);
    offer(clean(1, LC_READY, 64'd0, 64'd1, 64'd100));
    offer(clean(1, 32'd0, 64'd7, 64'd1, 64'd100));
    offer(clean(1, 32'd6, 64'd7, 64'd1, 64'd100));
    offer(clean(1, 32'hFFFF_FFFF, 64'd7, 64'd1, 64'd100));
    offer(clean(1, LC_RETIRED, 64'd7, 64'd1, 64'd100));
    offer(clean(1, LC_FAULTED, 64'd7, 64'd1, 64'd100));
    offer(clean(1, LC_STARTING, 64'd7, 64'd1, 64'd100));
    offer(clean(1, LC_READY, 64'd7, 64'd1, 64'd102));
    offer(clean(1, LC_READY, 64'd7, 64'd1, 64'd103));
    offer(clean(1, LC_DRAINING, 64'd7, 64'd1, 64'd50));
    offer(clean(1, LC_READY, 64'd7, 64'd2, 64'd200));
    offer(clean(1, LC_READY, 64'd7, 64'd2, 64'd203));
    offer(clean(1, LC_READY, 64'd8, 64'd2, 64'd203));
    offer(clean(1, LC_DRAINING, 64'd8, 64'd2, 64'd205));
    offer(clean(2, LC_READY, 64'd5, 64'd0, 64'd0));
    offer(clean(2, LC_READY, 64'd5, 64'd0, 64'd3));

    run_phase(rand64(), 9'd256, 32'd1, 130, 1'b0);
    run_phase(64'd0, 9'd1, 32'hFFFF_FFFF, 110, 1'b0);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 9'd9, 32'd16, 130, 1'b1);
    run_phase(rand64(), 9'd0, 32'd50, 40, 1'b0);
    run_phase(rand64(), 9'd256, 32'd0, 30, 1'b0);
    run_phase(rand64(), PeerW'($urandom_range(2, 255)), $urandom_range(2, 5000), 150, 1'b1);
    run_phase(rand64(), 9'd256, $urandom, 130, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ peer_heartbeat_stale_monitor_top.f @@
hdl/phsm_pkg.sv
hdl/phsm_front.sv
hdl/phsm_queue.sv
hdl/phsm_back.sv
hdl/peer_heartbeat_stale_monitor_top.sv
tb/stale_verdict_checker.sv
tb/tb.sv
